>>> hdl/stf_pkg.sv
// Shared constants, register map and sine helper for the stereo flanger.
`default_nettype none
package stf_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int FRAME_W   = 2 * SAMPLE_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam int BASE_W  = 10;
	localparam int DEPTH_W = 9;
	localparam int STEP_W  = 32;
	localparam int PHASE_W = 32;
	localparam int SINE_W  = 15;
	localparam int PROD_W  = DEPTH_W + SINE_W;
	localparam int OFFS_W  = PROD_W + 1 - 15;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd2;

	localparam logic [BASE_W-1:0]  BASE_RESET  = 10'd265;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 9'd176;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd24348;

	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(16384);

	// Quarter-wave sine magnitude in Q15 for x in 0..32768.
	function automatic logic [SINE_W-1:0] quarter_sine(input logic [31:0] x);
		logic [31:0] x2;
		logic [31:0] inner;
		logic [31:0] t;
		logic [31:0] s;
		x2    = (x * x) >> 15;
		inner = 32'd21167 - ((32'd2605 * x2) >> 15);
		t     = 32'd51472 - ((x2 * inner) >> 15);
		s     = (x * t) >> 15;
		return (s > 32'd32767) ? 15'h7fff : s[SINE_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> hdl/stf_queue.sv
// Short job queue between the address front end and the delay-line back end.
`default_nettype none
module stf_queue #(
	parameter int WIDTH = 53,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           push_data,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           pop_data,
	output logic      [$clog2(DEPTH+1)-1:0] count,
	output logic                            empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign pop_data = slot_q[rd_ptr_q];
	assign count    = count_q;
	assign empty    = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q != CW'(DEPTH))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("job queue underflow");

endmodule
`default_nettype wire

>>> hdl/stf_front.sv
// Front end: takes frames, runs the LFO and works out each frame's ring addresses.
`default_nettype none
module stf_front #(
	parameter int RING_FRAMES     = 1024,
	parameter int SINE_TABLE_BITS = 8,
	parameter int Q_DEPTH         = 4
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [stf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [stf_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [stf_pkg::FRAME_W-1:0]            in_data,
	input  wire logic [$clog2(Q_DEPTH+1)-1:0]           q_count,
	output logic                                        push,
	output logic [1+2*$clog2(RING_FRAMES)+stf_pkg::FRAME_W-1:0] push_data
);
	import stf_pkg::*;

	localparam int AW     = $clog2(RING_FRAMES);
	localparam int DW     = ((AW > BASE_W) ? AW : BASE_W) + 2;
	localparam int QBITS  = SINE_TABLE_BITS - 2;
	localparam int QUARTER = 1 << QBITS;
	localparam int QCW    = $clog2(Q_DEPTH + 1);
	localparam logic [AW-1:0]        WP_LAST = AW'(RING_FRAMES - 1);
	localparam logic [AW:0]          FILL_MAX = (AW + 1)'(RING_FRAMES);
	localparam logic signed [DW-1:0] D_MIN = DW'(1);
	localparam logic signed [DW-1:0] D_MAX = DW'(RING_FRAMES - 1);

	// Quarter-wave table, built at elaboration.
	logic [SINE_W-1:0] sine_lut [QUARTER+1];
	for (genvar g = 0; g <= QUARTER; g++) begin : g_lut
		assign sine_lut[g] = quarter_sine(32'(g) << (15 - QBITS));
	end

	logic [BASE_W-1:0]  base_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [STEP_W-1:0]  step_q;
	logic [PHASE_W-1:0] phase_q;
	logic [AW-1:0]      wp_q;
	logic [AW:0]        fill_q;

	logic               accept;
	logic [AW-1:0]      wp_next;
	logic [AW:0]        fill_next;
	logic [SINE_TABLE_BITS-1:0] k;
	logic [QBITS:0]     pos;
	logic [QCW:0]       pending;

	logic                v_s1;
	logic [FRAME_W-1:0]  frame_s1;
	logic [AW-1:0]       wp_s1;
	logic [AW:0]         fill_s1;
	logic [SINE_W-1:0]   sine_s1;
	logic                neg_s1;

	logic                v_s2;
	logic [FRAME_W-1:0]  frame_s2;
	logic [AW-1:0]       wp_s2;
	logic [AW:0]         fill_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic                neg_s2;

	logic [PROD_W:0]         rounded;
	logic [OFFS_W-1:0]       offs;
	logic signed [DW-1:0]    d_raw;
	logic [AW-1:0]           d_sel;
	logic [AW:0]             rd_wrap;
	logic [AW-1:0]           rd_addr;
	logic                    rd_zero;

	assign pending  = (QCW + 1)'(q_count) + (QCW + 1)'(v_s1) + (QCW + 1)'(v_s2);
	assign in_ready = (pending < (QCW + 1)'(Q_DEPTH));
	assign accept   = in_valid && in_ready;

	assign wp_next   = (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
	assign fill_next = (fill_q == FILL_MAX) ? fill_q : fill_q + 1'b1;

	// Top phase bits pick a point on the circle; odd quadrants run the table backwards.
	assign k   = phase_q[PHASE_W-1 -: SINE_TABLE_BITS];
	assign pos = k[QBITS] ? ((QBITS + 1)'(QUARTER) - {1'b0, k[QBITS-1:0]})
	                      : {1'b0, k[QBITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RESET;
			depth_q <= DEPTH_RESET;
			step_q  <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_DELAY: base_q  <= cfg_data[BASE_W-1:0];
				REG_DEPTH:      depth_q <= cfg_data[DEPTH_W-1:0];
				REG_PHASE_STEP: step_q  <= cfg_data[STEP_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			wp_q    <= '0;
			fill_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_q + step_q;
				wp_q    <= wp_next;
				fill_q  <= fill_next;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= in_data;
			wp_s1    <= wp_next;
			fill_s1  <= fill_next;
			sine_s1  <= sine_lut[pos];
			neg_s1   <= k[SINE_TABLE_BITS-1];
		end
		if (v_s1) begin
			frame_s2 <= frame_s1;
			wp_s2    <= wp_s1;
			fill_s2  <= fill_s1;
			prod_s2  <= PROD_W'(depth_q) * PROD_W'(sine_s1);
			neg_s2   <= neg_s1;
		end
	end

	always_comb begin
		rounded = {1'b0, prod_s2} + ROUND_HALF;
		offs    = rounded[PROD_W:15];
		d_raw   = neg_s2 ? (DW'(base_q) - DW'(offs)) : (DW'(base_q) + DW'(offs));
		if (d_raw < D_MIN) begin
			d_sel = AW'(1);
		end else if (d_raw > D_MAX) begin
			d_sel = WP_LAST;
		end else begin
			d_sel = d_raw[AW-1:0];
		end
		rd_wrap = {1'b0, wp_s2} + FILL_MAX - {1'b0, d_sel};
		rd_addr = (wp_s2 >= d_sel) ? (wp_s2 - d_sel) : rd_wrap[AW-1:0];
		// Frames further back than anything written so far still read as zero.
		rd_zero = ({1'b0, d_sel} >= fill_s2);
	end

	assign push      = v_s2;
	assign push_data = {rd_zero, rd_addr, wp_s2, frame_s2};

	a_room_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> q_count != QCW'(Q_DEPTH))
		else $error("frame reached the queue with no room left");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill count beyond ring size");

endmodule
`default_nettype wire

>>> hdl/stf_back.sv
// Back end: ring delay line write and read, dry/wet mix and output register.
`default_nettype none
module stf_back #(
	parameter int RING_FRAMES = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   q_empty,
	input  wire logic [1+2*$clog2(RING_FRAMES)+stf_pkg::FRAME_W-1:0] q_data,
	output logic                                        pop,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic      [stf_pkg::FRAME_W-1:0]            out_data
);
	import stf_pkg::*;

	localparam int AW = $clog2(RING_FRAMES);

	logic [FRAME_W-1:0] ring [RING_FRAMES];

	logic               job_zero;
	logic [AW-1:0]      job_rd;
	logic [AW-1:0]      job_wp;
	logic [FRAME_W-1:0] job_frame;

	logic               v_s1;
	logic [FRAME_W-1:0] dry_s1;
	logic [FRAME_W-1:0] wet_s1;
	logic               zero_s1;
	logic               adv_s1;

	logic               out_valid_q;
	logic [FRAME_W-1:0] out_data_q;

	logic [FRAME_W-1:0] wet;
	logic [SAMPLE_W:0]  sum_l;
	logic [SAMPLE_W:0]  sum_r;

	assign {job_zero, job_rd, job_wp, job_frame} = q_data;

	assign adv_s1 = v_s1 && (!out_valid_q || out_ready);
	assign pop    = !q_empty && (!v_s1 || adv_s1);

	// The read address always differs from the write address, so old data is fine.
	always_ff @(posedge clk) begin
		if (pop) begin
			ring[job_wp] <= job_frame;
			wet_s1       <= ring[job_rd];
			dry_s1       <= job_frame;
			zero_s1      <= job_zero;
		end
	end

	always_comb begin
		wet   = zero_s1 ? '0 : wet_s1;
		sum_l = {dry_s1[SAMPLE_W-1], dry_s1[SAMPLE_W-1:0]}
		      + {wet[SAMPLE_W-1], wet[SAMPLE_W-1:0]};
		sum_r = {dry_s1[FRAME_W-1], dry_s1[FRAME_W-1:SAMPLE_W]}
		      + {wet[FRAME_W-1], wet[FRAME_W-1:SAMPLE_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= pop || (v_s1 && !adv_s1);
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= {sum_r[SAMPLE_W:1], sum_l[SAMPLE_W:1]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_pending_read_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |=> v_s1 && !$past(pop))
		else $error("stalled ring read lost or overwritten");

endmodule
`default_nettype wire

>>> hdl/stereo_flanger.sv
// Stereo flanger top level: sine-LFO modulated ring delay with a half dry / half wet mix.
// Path to m_tvalid: front s1 and s2, job queue, back-end s1, output register.
// Throughput: one frame per cycle if m_tready is high, bound by single ring write/read.
// s_tready falls only when the job queue and the two front stages would overfill.
// Reset clears control, LFO phase, write pointer and fill count; the ring needs no
// clearing pass, since frames not yet written read as zero through the fill count.
`default_nettype none
module stereo_flanger #(
	parameter int RING_FRAMES     = 1024,
	parameter int SINE_TABLE_BITS = 8,
	parameter int Q_DEPTH         = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [stf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [stf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [stf_pkg::FRAME_W-1:0]    s_tdata,  // left_in[15:0], right_in[31:16]
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [stf_pkg::FRAME_W-1:0]    m_tdata   // left_out[15:0], right_out[31:16]
);
	import stf_pkg::*;

	localparam int AW    = $clog2(RING_FRAMES);
	localparam int JOB_W = 1 + 2 * AW + FRAME_W;

	logic                         push;
	logic [JOB_W-1:0]             push_data;
	logic                         pop;
	logic [JOB_W-1:0]             pop_data;
	logic [$clog2(Q_DEPTH+1)-1:0] q_count;
	logic                         q_empty;

	stf_front #(
		.RING_FRAMES     (RING_FRAMES),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.Q_DEPTH         (Q_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	stf_queue #(
		.WIDTH (JOB_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.count     (q_count),
		.empty     (q_empty)
	);

	stf_back #(
		.RING_FRAMES (RING_FRAMES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire
